// ===== hw/rtl/prc_pkg.sv =====
// shared types and constants for the prime range counter
package prc_pkg;

  localparam int NUMBER_W = 24;
  localparam int ROOT_W   = (NUMBER_W + 1) / 2;
  localparam int DIV_W    = ROOT_W + 1;
  localparam int SQ_XW    = 2 * ROOT_W;
  localparam int SQ_CW    = $clog2(ROOT_W);
  localparam int DIV_CW   = $clog2(NUMBER_W);

  typedef struct packed {
    logic [NUMBER_W-1:0] lower_bound;
    logic [NUMBER_W-1:0] upper_bound;
    logic                restart_total;
  } in_item_t;

  typedef struct packed {
    logic [NUMBER_W-1:0] segment_count;
    logic [NUMBER_W-1:0] total_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic cand_inc;
    logic sqrt_start;
    logic sqrt_step;
    logic div_init;
    logic div_start;
    logic div_step;
    logic d_inc;
    logic count_inc;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic below_two;
    logic last_cand;
    logic sqrt_last;
    logic d_over;
    logic div_last;
    logic rem_zero;
  } dp_status_t;

endpackage

// ===== hw/rtl/prime_range_counter_top.sv =====
// top level of the prime range counter
//
//   channel  handshake               payload
//   in       in_valid / in_stall     in_item  (lower_bound, upper_bound, restart_total)
//   out      out_valid / out_stall   out_item (segment_count, total_count)
//
// one item at a time; in_stall is high from the cycle after a transfer until the result
// is loaded into the output register, which then waits for out_stall to drop
// per candidate: bookkeeping, a digit-by-digit square root, then per trial divisor from 2
// up to the root a pass of the bit-serial remainder unit, and a final step counts a prime;
// an empty range skips the loops and goes straight to the result
// rst is synchronous and clears the state machine, the output valid and the running total
module prime_range_counter_top import prc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  prc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

// ===== hw/rtl/prc_ctrl.sv =====
// sequencer for the candidate, square root and trial division loops
module prc_ctrl import prc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CAND   = 3'd1;
  localparam logic [2:0] S_SQRT   = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_NEXT   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.empty ? S_FINISH : S_CAND;
        end
      end
      S_CAND: begin
        if (status.below_two) begin
          state_next = S_NEXT;
        end else begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_last) begin
          cmd.div_init = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_TEST: begin
        if (status.d_over) begin
          cmd.count_inc = 1'b1;
          state_next    = S_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.rem_zero) begin
          state_next = S_NEXT;
        end else begin
          cmd.d_inc  = 1'b1;
          state_next = S_TEST;
        end
      end
      S_NEXT: begin
        if (status.last_cand) begin
          state_next = S_FINISH;
        end else begin
          cmd.cand_inc = 1'b1;
          state_next   = S_CAND;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && out_stall) || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/prc_datapath.sv =====
// candidate, root, divisor, remainder and count registers
module prc_datapath import prc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_item,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output out_item_t  out_item
);

  logic [NUMBER_W-1:0] cand;
  logic [NUMBER_W-1:0] hi;
  logic                restart;
  logic [NUMBER_W-1:0] count;
  logic [NUMBER_W-1:0] total;

  logic [SQ_XW-1:0]    sq_x;
  logic [ROOT_W:0]     sq_rem;
  logic [ROOT_W-1:0]   root;
  logic [SQ_CW-1:0]    sq_cnt;

  logic [DIV_W-1:0]    divisor;
  logic [DIV_W-1:0]    part;
  logic [NUMBER_W-1:0] div_x;
  logic [DIV_CW-1:0]   div_cnt;

  // square root digit step
  logic [ROOT_W+2:0]   sq_sh;
  logic [ROOT_W+2:0]   sq_trial;
  logic                sq_ge;
  logic [ROOT_W+2:0]   sq_diff;

  // remainder bit step
  logic [DIV_W:0]      dv_sh;
  logic [DIV_W:0]      dv_d;
  logic                dv_ge;
  logic [DIV_W:0]      dv_diff;

  // total update
  logic [NUMBER_W-1:0] base;
  logic [NUMBER_W:0]   sum;
  logic [NUMBER_W-1:0] total_next;

  assign sq_sh    = {sq_rem, sq_x[SQ_XW-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;

  assign dv_sh   = {part, div_x[NUMBER_W-1]};
  assign dv_d    = {1'b0, divisor};
  assign dv_ge   = (dv_sh >= dv_d);
  assign dv_diff = dv_sh - dv_d;

  assign base       = restart ? '0 : total;
  assign sum        = {1'b0, base} + {1'b0, count};
  assign total_next = sum[NUMBER_W] ? '1 : sum[NUMBER_W-1:0];

  assign status.empty     = (in_item.lower_bound > in_item.upper_bound);
  assign status.below_two = (cand[NUMBER_W-1:1] == '0);
  assign status.last_cand = (cand == hi);
  assign status.sqrt_last = (sq_cnt == '0);
  assign status.d_over    = (divisor > {1'b0, root});
  assign status.div_last  = (div_cnt == '0);
  assign status.rem_zero  = (part == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.finish) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand    <= in_item.lower_bound;
      hi      <= in_item.upper_bound;
      restart <= in_item.restart_total;
      count   <= '0;
    end else begin
      if (cmd.cand_inc) begin
        cand <= cand + 1'b1;
      end
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
    end

    if (cmd.sqrt_start) begin
      sq_x   <= SQ_XW'(cand);
      sq_rem <= '0;
      root   <= '0;
      sq_cnt <= SQ_CW'(ROOT_W - 1);
    end else if (cmd.sqrt_step) begin
      sq_x   <= sq_x << 2;
      sq_rem <= sq_ge ? sq_diff[ROOT_W:0] : sq_sh[ROOT_W:0];
      root   <= {root[ROOT_W-2:0], sq_ge};
      sq_cnt <= sq_cnt - 1'b1;
    end

    if (cmd.div_init) begin
      divisor <= DIV_W'(2);
    end else if (cmd.d_inc) begin
      divisor <= divisor + 1'b1;
    end

    if (cmd.div_start) begin
      part    <= '0;
      div_x   <= cand;
      div_cnt <= DIV_CW'(NUMBER_W - 1);
    end else if (cmd.div_step) begin
      part    <= dv_ge ? dv_diff[DIV_W-1:0] : dv_sh[DIV_W-1:0];
      div_x   <= div_x << 1;
      div_cnt <= div_cnt - 1'b1;
    end

    if (cmd.finish) begin
      out_item.segment_count <= count;
      out_item.total_count   <= total_next;
    end
  end

endmodule

// ===== hw/rtl/prc_checker.sv =====
// port level checks for the prime range counter and their binding
module prc_checker import prc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("input dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result dropped or changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

  a_total_covers_segment: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.total_count >= out_item.segment_count)
    else $error("running total below segment count");

endmodule

bind prime_range_counter_top prc_checker u_prc_checker (.*);
